/* design/cbor_enc_pkg.sv */
// Shared types, codes and head builder for the CBOR item head encoder.
package cbor_enc_pkg;

   typedef enum logic [2:0] {
      CMD_BEGIN     = 3'd0,
      CMD_UINT      = 3'd1,
      CMD_SINT      = 3'd2,
      CMD_BOOL      = 3'd3,
      CMD_FLOAT     = 3'd4,
      CMD_TEXT_HDR  = 3'd5,
      CMD_TEXT_BYTE = 3'd6,
      CMD_MAP_HDR   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_REJECT   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_BEGIN  = 2'd0,
      KIND_BYTES  = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   localparam logic [2:0] MT_UINT   = 3'd0;
   localparam logic [2:0] MT_NINT   = 3'd1;
   localparam logic [2:0] MT_TEXT   = 3'd3;
   localparam logic [2:0] MT_MAP    = 3'd5;
   localparam logic [2:0] MT_SIMPLE = 3'd7;

   localparam logic [4:0] AI_INLINE_MAX = 5'd23;
   localparam logic [4:0] AI_ONE_BYTE   = 5'd24;
   localparam logic [4:0] AI_TWO_BYTES  = 5'd25;
   localparam logic [4:0] AI_FOUR_BYTES = 5'd26;
   localparam logic [4:0] AI_FALSE      = 5'd20;
   localparam logic [4:0] AI_TRUE       = 5'd21;

   localparam logic [15:0] CAPACITY_RESET = 16'd256;
   localparam logic [31:0] TEXT_LEN_MAX   = 32'h0000_FFFF;

   typedef struct packed {
      logic [4:0][7:0] seq;   // seq[0] goes out first
      logic [2:0]      len;
   } head_type;

   typedef struct packed {
      kind_type        kind;
      logic [4:0][7:0] seq;
      logic [2:0]      len;
   } item_type;

   function automatic head_type make_head(input logic [2:0] major, input logic [31:0] val);
      head_type h;
      h.seq = '0;
      if (val <= {27'd0, AI_INLINE_MAX}) begin
         h.seq[0] = {major, val[4:0]};
         h.len    = 3'd1;
      end else if (val <= 32'h0000_00FF) begin
         h.seq[0] = {major, AI_ONE_BYTE};
         h.seq[1] = val[7:0];
         h.len    = 3'd2;
      end else if (val <= 32'h0000_FFFF) begin
         h.seq[0] = {major, AI_TWO_BYTES};
         h.seq[1] = val[15:8];
         h.seq[2] = val[7:0];
         h.len    = 3'd3;
      end else begin
         h.seq[0] = {major, AI_FOUR_BYTES};
         h.seq[1] = val[31:24];
         h.seq[2] = val[23:16];
         h.seq[3] = val[15:8];
         h.seq[4] = val[7:0];
         h.len    = 3'd5;
      end
      return h;
   endfunction

endpackage

/* design/cbor_enc_decode.sv */
// Input register stage: builds the byte sequence of one item.
module cbor_enc_decode (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [2:0]                in_command,
   input  logic [31:0]               in_uint,
   input  logic [31:0]               in_int,
   input  logic                      in_flag,
   input  logic [31:0]               in_float,
   input  logic [7:0]                in_text,
   output logic                      dec_valid,
   output cbor_enc_pkg::item_type    dec_item,
   input  logic                      dec_take
);
   import cbor_enc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   head_type head;

   assign in_ready  = !valid_ff || dec_take;
   assign dec_valid = valid_ff;
   assign dec_item  = item_ff;

   always_comb begin
      head         = make_head(MT_UINT, in_uint);
      item_in      = '0;
      item_in.kind = KIND_BYTES;
      case (cmd_type'(in_command))
         CMD_BEGIN: begin
            item_in.kind = KIND_BEGIN;
         end
         CMD_UINT: begin
            item_in.seq = head.seq;
            item_in.len = head.len;
         end
         CMD_SINT: begin
            if (in_int[31]) begin
               head = make_head(MT_NINT, ~in_int);
            end else begin
               head = make_head(MT_UINT, in_int);
            end
            item_in.seq = head.seq;
            item_in.len = head.len;
         end
         CMD_BOOL: begin
            item_in.seq[0] = {MT_SIMPLE, in_flag ? AI_TRUE : AI_FALSE};
            item_in.len    = 3'd1;
         end
         CMD_FLOAT: begin
            item_in.seq[0] = {MT_SIMPLE, AI_FOUR_BYTES};
            item_in.seq[1] = in_float[31:24];
            item_in.seq[2] = in_float[23:16];
            item_in.seq[3] = in_float[15:8];
            item_in.seq[4] = in_float[7:0];
            item_in.len    = 3'd5;
         end
         CMD_TEXT_HDR: begin
            if (in_uint > TEXT_LEN_MAX) begin
               item_in.kind = KIND_REJECT;
            end else begin
               head        = make_head(MT_TEXT, in_uint);
               item_in.seq = head.seq;
               item_in.len = head.len;
            end
         end
         CMD_TEXT_BYTE: begin
            item_in.seq[0] = in_text;
            item_in.len    = 3'd1;
         end
         CMD_MAP_HDR: begin
            head        = make_head(MT_MAP, in_uint);
            item_in.seq = head.seq;
            item_in.len = head.len;
         end
         default: begin
            item_in.kind = KIND_REJECT;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (dec_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

/* design/cbor_enc_emit.sv */
// Byte serializer with capacity check, payload state and result register.
module cbor_enc_emit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [15:0]               capacity,
   input  logic                      dec_valid,
   input  cbor_enc_pkg::item_type    dec_item,
   output logic                      dec_take,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [7:0]                out_byte,
   output logic [15:0]               out_pos,
   output logic [1:0]                out_status,
   output logic                      out_last
);
   import cbor_enc_pkg::*;

   logic       cur_valid_ff, cur_valid_in;
   item_type   cur_ff;
   logic [2:0] idx_ff, idx_in;
   logic [15:0] count_ff, count_in;
   logic       failed_ff, failed_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic [15:0] rsp_pos_ff;
   status_type rsp_status_ff;
   logic       rsp_last_ff;

   logic       out_free, step, done, load;
   logic [7:0] sel_byte, res_byte;
   status_type res_status;
   logic       res_last;

   assign out_free = !rsp_valid_ff || out_ready;
   assign step     = cur_valid_ff && (cur_ff.kind == KIND_BEGIN || out_free);

   always_comb begin
      case (idx_ff)
         3'd0:    sel_byte = cur_ff.seq[0];
         3'd1:    sel_byte = cur_ff.seq[1];
         3'd2:    sel_byte = cur_ff.seq[2];
         3'd3:    sel_byte = cur_ff.seq[3];
         3'd4:    sel_byte = cur_ff.seq[4];
         default: sel_byte = 8'd0;
      endcase
   end

   always_comb begin
      res_byte   = 8'd0;
      res_status = ST_OK;
      res_last   = 1'b1;
      done       = 1'b1;
      count_in   = count_ff;
      failed_in  = failed_ff;
      if (cur_ff.kind == KIND_BEGIN) begin
         count_in  = 16'd0;
         failed_in = 1'b0;
      end else if (failed_ff || cur_ff.kind == KIND_REJECT) begin
         res_status = ST_REJECT;
      end else if (count_ff >= capacity) begin
         res_status = ST_OVERFLOW;
         failed_in  = 1'b1;
      end else begin
         res_byte = sel_byte;
         res_last = (idx_ff == cur_ff.len - 3'd1);
         done     = res_last;
         count_in = count_ff + 16'd1;
      end
   end

   assign load     = dec_valid && (!cur_valid_ff || (step && done));
   assign dec_take = load;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_valid_in = 1'b1;
         idx_in       = 3'd0;
      end else if (step && done) begin
         cur_valid_in = 1'b0;
      end else if (step) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step && cur_ff.kind != KIND_BEGIN) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
         count_ff     <= 16'd0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            count_ff  <= count_in;
            failed_ff <= failed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= dec_item;
      end
      if (step && cur_ff.kind != KIND_BEGIN) begin
         rsp_byte_ff   <= res_byte;
         rsp_pos_ff    <= count_ff;
         rsp_status_ff <= res_status;
         rsp_last_ff   <= res_last;
      end
   end

   assign out_valid  = rsp_valid_ff;
   assign out_byte   = rsp_byte_ff;
   assign out_pos    = rsp_pos_ff;
   assign out_status = rsp_status_ff;
   assign out_last   = rsp_last_ff;

   // error results always close their item
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_last_ff)
      else $error("error result without last flag");

   a_ovf_fail: assert property (@(posedge clock) disable iff (reset)
      step && res_status == ST_OVERFLOW |=> failed_ff)
      else $error("overflow did not set failed");

   a_fail_hold: assert property (@(posedge clock) disable iff (reset)
      failed_ff && !(step && cur_ff.kind == KIND_BEGIN) |=> failed_ff)
      else $error("failed cleared without begin");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && cur_ff.kind == KIND_BYTES |-> idx_ff < cur_ff.len)
      else $error("byte index past item length");

endmodule

/* design/cbor_item_head_encoder_unit.sv */
// Top level of the CBOR item head encoder: ports, capacity register, stage wiring.
// Path: the first result of an item passes the input register, the serializer register
// and the result register; later bytes of the item follow one per cycle while the result
// output is not stalled.
// Throughput: one result byte per cycle while the output is not stalled, for items of 1 to 5
// bytes; begin items produce no result.
// Reset (synchronous, active high) clears byte count, failed flag and all valid bits,
// and sets the capacity register to 256.
module cbor_item_head_encoder_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] uint_value, [63:32] int_value, [64] flag_value, [96:65] float_bits,
   // [104:97] text_byte, [111:105] zero
   input  logic [111:0] req_tdata,
   // [2:0] command
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [7:0] data_byte, [23:8] byte_position
   output logic [23:0]  rsp_tdata,
   // [1:0] status
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);
   import cbor_enc_pkg::*;

   logic [15:0] capacity_ff;
   logic        dec_valid, dec_take;
   item_type    dec_item;
   logic [7:0]  out_byte;
   logic [15:0] out_pos;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_data;
      end
   end

   cbor_enc_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_command (req_tuser),
      .in_uint    (req_tdata[31:0]),
      .in_int     (req_tdata[63:32]),
      .in_flag    (req_tdata[64]),
      .in_float   (req_tdata[96:65]),
      .in_text    (req_tdata[104:97]),
      .dec_valid  (dec_valid),
      .dec_item   (dec_item),
      .dec_take   (dec_take)
   );

   cbor_enc_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .dec_valid  (dec_valid),
      .dec_item   (dec_item),
      .dec_take   (dec_take),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (out_byte),
      .out_pos    (out_pos),
      .out_status (rsp_tuser),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {out_pos, out_byte};

endmodule

/* dv/cbor_item_head_encoder_unit_tb.sv */
// Self-checking testbench for the CBOR item head encoder: directed table, then random payloads.
`timescale 1ns / 100ps

module cbor_item_head_encoder_unit_tb;
   import cbor_enc_pkg::*;

   localparam int DRAIN_PAD       = 8;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int ITEMS_PER_PHASE = 38;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] pos;
      status_type  st;
      logic        last;
   } enc_result_t;

   typedef struct packed {
      logic        is_csr;
      cmd_type     cmd;
      logic [31:0] val;
      logic        fixed;
      logic [7:0]  fix_data;
      status_type  fix_status;
   } plan_row_t;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata  = '0;
   logic [2:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_data   = '0;

   enc_result_t  pending_results[$];
   enc_result_t  got_exp;
   plan_row_t    stim_plan[$];

   logic [15:0]  enc_capacity = CAPACITY_RESET;
   logic [15:0]  enc_count    = '0;
   logic         enc_failed   = 1'b0;

   logic         fix_armed    = 1'b0;
   logic [7:0]   fix_data     = '0;
   status_type   fix_status   = ST_OK;

   int           send_idle_pct = 0;
   int           stall_pct     = 0;
   int           mismatches    = 0;
   int           idle_cycles   = 0;

   cbor_item_head_encoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic push_expect(input logic [7:0] d, input status_type s, input logic l);
      enc_result_t r;
      r.data_byte = d;
      r.pos       = enc_count;
      r.st        = s;
      r.last      = l;
      if (fix_armed) begin
         r.data_byte = fix_data;
         r.st        = fix_status;
         fix_armed   = 1'b0;
      end
      pending_results.push_back(r);
   endtask

   // shortest-form head, first byte in the low bits
   task automatic head_bytes(input logic [2:0] major, input logic [31:0] v,
                             output logic [39:0] seq, output int n);
      seq = '0;
      if (v < 32'd24) begin
         seq[7:0] = {major, v[4:0]};
         n = 1;
      end else if (v < 32'd256) begin
         seq[15:0] = {v[7:0], major, AI_ONE_BYTE};
         n = 2;
      end else if (v < 32'h1_0000) begin
         seq[23:0] = {v[7:0], v[15:8], major, AI_TWO_BYTES};
         n = 3;
      end else begin
         seq = {v[7:0], v[15:8], v[23:16], v[31:24], major, AI_FOUR_BYTES};
         n = 5;
      end
   endtask

   task automatic predict_item(input cmd_type c, input logic [31:0] u, input logic [31:0] i,
                               input logic fl, input logic [31:0] f, input logic [7:0] t);
      logic [39:0] seq;
      int n;
      if (c == CMD_BEGIN) begin
         enc_count  = '0;
         enc_failed = 1'b0;
         return;
      end
      if (enc_failed) begin
         push_expect(8'd0, ST_REJECT, 1'b1);
         return;
      end
      seq = '0;
      n   = 1;
      case (c)
         CMD_UINT: head_bytes(MT_UINT, u, seq, n);
         CMD_SINT: begin
            if (i[31]) head_bytes(MT_NINT, ~i, seq, n);
            else head_bytes(MT_UINT, i, seq, n);
         end
         CMD_BOOL: seq[7:0] = {MT_SIMPLE, fl ? AI_TRUE : AI_FALSE};
         CMD_FLOAT: begin
            seq = {f[7:0], f[15:8], f[23:16], f[31:24], MT_SIMPLE, AI_FOUR_BYTES};
            n   = 5;
         end
         CMD_TEXT_HDR: begin
            if (u > TEXT_LEN_MAX) begin
               push_expect(8'd0, ST_REJECT, 1'b1);
               return;
            end
            head_bytes(MT_TEXT, u, seq, n);
         end
         CMD_TEXT_BYTE: seq[7:0] = t;
         default: head_bytes(MT_MAP, u, seq, n);
      endcase
      for (int k = 0; k < n; k++) begin
         if (enc_count >= enc_capacity) begin
            enc_failed = 1'b1;
            push_expect(8'd0, ST_OVERFLOW, 1'b1);
            return;
         end
         push_expect(seq[8*k +: 8], ST_OK, k == n - 1);
         enc_count = enc_count + 16'd1;
      end
   endtask

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            note_mismatch($sformatf("unexpected result data %h status %0d last %0b",
                                    rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            got_exp = pending_results.pop_front();
            if (rsp_tdata[7:0] !== got_exp.data_byte || rsp_tdata[23:8] !== got_exp.pos ||
                rsp_tuser !== got_exp.st || rsp_tlast !== got_exp.last) begin
               note_mismatch($sformatf(
                  "exp byte %02h pos %0d status %0d last %0b, got byte %02h pos %0d status %0d last %0b",
                  got_exp.data_byte, got_exp.pos, got_exp.st, got_exp.last,
                  rsp_tdata[7:0], rsp_tdata[23:8], rsp_tuser, rsp_tlast));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic plan_add(input logic is_csr, input cmd_type c, input logic [31:0] v,
                           input logic fx, input logic [7:0] fd, input status_type fs);
      plan_row_t r;
      r.is_csr     = is_csr;
      r.cmd        = c;
      r.val        = v;
      r.fixed      = fx;
      r.fix_data   = fd;
      r.fix_status = fs;
      stim_plan.push_back(r);
   endtask

   task automatic send_cmd(input cmd_type c, input logic [31:0] v);
      logic [31:0] u;
      logic [31:0] i;
      logic [31:0] f;
      logic        fl;
      logic [7:0]  t;
      u  = $urandom;
      i  = $urandom;
      f  = $urandom;
      fl = 1'($urandom_range(1));
      t  = 8'($urandom_range(255));
      case (c)
         CMD_UINT, CMD_TEXT_HDR, CMD_MAP_HDR: u = v;
         CMD_SINT: i = v;
         CMD_BOOL: fl = v[0];
         CMD_FLOAT: f = v;
         CMD_TEXT_BYTE: t = v[7:0];
         default: ;
      endcase
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {7'd0, t, f, fl, i, u};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(c, u, i, fl, f, t);
      @(negedge clock);
   endtask

   // waits for every pending result, then lets a begin-only tail finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_PAD) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      enc_capacity = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(4))
         0: return $urandom_range(23);
         1: return $urandom_range(255, 24);
         2: return $urandom_range(65535, 256);
         3: return $urandom;
         default: begin
            case ($urandom_range(6))
               0: return 32'd23;
               1: return 32'd24;
               2: return 32'd255;
               3: return 32'd256;
               4: return 32'h0000_FFFF;
               5: return 32'h0001_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   task automatic run_random(input int n_items);
      int          sent;
      int          len;
      cmd_type     c;
      logic [31:0] v;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 4) settle();
         if ($urandom_range(99) < 15) begin
            c = cmd_type'($urandom_range(7));
            send_cmd(c, rand_word());
            sent++;
         end else begin
            send_cmd(CMD_BEGIN, 32'd0);
            sent++;
            repeat ($urandom_range(6, 1)) begin
               c = cmd_type'($urandom_range(7, 1));
               if (c == CMD_TEXT_BYTE) c = CMD_TEXT_HDR;
               v = rand_word();
               if (c == CMD_SINT && $urandom_range(1)) v = ~v;
               if (c == CMD_TEXT_HDR && $urandom_range(4) != 0) v = $urandom_range(6);
               send_cmd(c, v);
               sent++;
               if (c == CMD_TEXT_HDR) begin
                  len = (v <= 32'd6) ? int'(v) : $urandom_range(3);
                  repeat (len) send_cmd(CMD_TEXT_BYTE, $urandom);
                  sent += len;
               end
            end
         end
      end
   endtask

   initial begin
      plan_row_t   r;
      logic [15:0] cap;
      plan_add(0, CMD_BEGIN,     32'd0,          0, 8'h00, ST_OK);
      plan_add(0, CMD_UINT,      32'd0,          1, 8'h00, ST_OK);
      plan_add(0, CMD_UINT,      32'd23,         1, 8'h17, ST_OK);
      plan_add(0, CMD_UINT,      32'd24,         0, 8'h00, ST_OK);
      plan_add(0, CMD_UINT,      32'd255,        0, 8'h00, ST_OK);
      plan_add(0, CMD_UINT,      32'd256,        0, 8'h00, ST_OK);
      plan_add(0, CMD_UINT,      32'h0000_FFFF,  0, 8'h00, ST_OK);
      plan_add(0, CMD_UINT,      32'h0001_0000,  0, 8'h00, ST_OK);
      plan_add(0, CMD_UINT,      32'hFFFF_FFFF,  1, 8'h1A, ST_OK);
      plan_add(0, CMD_SINT,      32'd0,          0, 8'h00, ST_OK);
      plan_add(0, CMD_SINT,      32'hFFFF_FFFF,  1, 8'h20, ST_OK);
      plan_add(0, CMD_SINT,      32'hFFFF_FFE7,  0, 8'h00, ST_OK);
      plan_add(0, CMD_SINT,      32'h7FFF_FFFF,  0, 8'h00, ST_OK);
      plan_add(0, CMD_SINT,      32'h8000_0000,  1, 8'h3A, ST_OK);
      plan_add(0, CMD_BOOL,      32'd0,          1, 8'hF4, ST_OK);
      plan_add(0, CMD_BOOL,      32'd1,          1, 8'hF5, ST_OK);
      plan_add(0, CMD_FLOAT,     32'hFFFF_FFFF,  1, 8'hFA, ST_OK);
      plan_add(0, CMD_TEXT_HDR,  32'h0000_FFFF,  1, 8'h79, ST_OK);
      plan_add(0, CMD_TEXT_HDR,  32'h0001_0000,  1, 8'h00, ST_REJECT);
      plan_add(0, CMD_TEXT_BYTE, 32'd255,        0, 8'h00, ST_OK);
      plan_add(0, CMD_MAP_HDR,   32'd24,         1, 8'hB8, ST_OK);
      plan_add(1, CMD_BEGIN,     32'd0,          0, 8'h00, ST_OK);
      plan_add(0, CMD_BEGIN,     32'd0,          0, 8'h00, ST_OK);
      plan_add(0, CMD_UINT,      32'd1,          1, 8'h00, ST_OVERFLOW);
      plan_add(0, CMD_BOOL,      32'd1,          1, 8'h00, ST_REJECT);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int s = 0; s < stim_plan.size(); s++) begin
         r = stim_plan[s];
         if (r.is_csr) begin
            settle();
            write_capacity(r.val[15:0]);
         end else begin
            fix_armed  = r.fixed;
            fix_data   = r.fix_data;
            fix_status = r.fix_status;
            send_cmd(r.cmd, r.val);
         end
      end

      for (int ph = 0; ph < 4; ph++) begin
         settle();
         case (ph)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
               cap           = 16'hFFFF;
            end
            1: begin
               send_idle_pct = 77;
               stall_pct     = 0;
               cap           = 16'($urandom_range(24));
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 77;
               cap           = 16'd1;
            end
            default: begin
               send_idle_pct = 31;
               stall_pct     = 31;
               cap           = 16'($urandom_range(64, 8));
            end
         endcase
         write_capacity(cap);
         run_random(ITEMS_PER_PHASE);
      end

      settle();
      if (pending_results.size() != 0) note_mismatch("results still pending at end of run");
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
